// ----- hw/rtl/rbs_pkg.sv -----
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared types and constants for the record bubble-sort core.
// ----------------------------------------------------------------------------
package rbs_pkg;

	localparam int MAX_RECORDS_DEF = 8;
	localparam int KEY_W           = 32;
	localparam int PAY_W           = 32;
	localparam int REC_W           = KEY_W + PAY_W;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} rec_t;

	typedef enum logic [2:0] {
		S_LOAD,
		S_SORT_START,
		S_SORT_FIRST,
		S_SORT_STEP,
		S_SORT_TAIL,
		S_EMIT_RD,
		S_EMIT_LD
	} state_t;

endpackage

// ----- hw/rtl/rbs_ram.sv -----
// ----------------------------------------------------------------------------
// rbs_ram
// Generic simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rbs_ram #(
	parameter int WIDTH  = rbs_pkg::REC_W,
	parameter int DEPTH  = rbs_pkg::MAX_RECORDS_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// read data holds until the next read
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/record_bubble_sort_core.sv -----
// ----------------------------------------------------------------------------
// record_bubble_sort_core
// Collects a set of key/payload records, bubble-sorts them by key, emits them.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one word per record, sort_key plus
//   payload. last_item closes the set. Words are taken one per cycle while the
//   core is loading; records past MAX_RECORDS are dropped and flag overflow.
//   Once the closing word is taken, in_stall stays high until the whole sorted
//   run has been handed to the output register.
//   Output channel (out_valid / out_stall): one word per stored record, keys
//   ascending, equal keys in arrival order, out_last on the final word and
//   overflow repeated on every word of the run.
// Phases, for a set of n stored records:
//   load: words are written to the record RAM in arrival order.
//   sort: each pass walks one comparator over the store, and passes repeat
//         until a pass makes no swap (at most n passes).
//   emit: a setup read, then 1 word per cycle while the receiver takes them.
// The single record RAM port pair feeds the one key comparator.
// Reset clears the sequencer, record count, dropped flag and output valid; the
// record RAM is not cleared, only entries of the current set are read.
// A stalled receiver freezes the output word and pauses emission.
// ----------------------------------------------------------------------------
module record_bubble_sort_core #(
	parameter int MAX_RECORDS = rbs_pkg::MAX_RECORDS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// input channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [rbs_pkg::KEY_W-1:0] sort_key,
	input  logic [rbs_pkg::PAY_W-1:0] payload,
	input  logic                     last_item,
	// output channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [rbs_pkg::KEY_W-1:0] out_key,
	output logic [rbs_pkg::PAY_W-1:0] out_payload,
	output logic                     out_last,
	output logic                     overflow
);

	localparam int IDX_W = $clog2(MAX_RECORDS);
	localparam int CNT_W = $clog2(MAX_RECORDS + 1);

	rbs_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0] count_q, count_d;     // records stored this set
	logic             dropped_q, dropped_d; // a record of this set was dropped
	logic             swapped_q, swapped_d; // current pass made a swap
	rbs_pkg::rec_t    hold_q, hold_d;       // record bubbling up in this pass
	logic [IDX_W-1:0] pos_q, pos_d;         // index of record on RAM read data
	logic [IDX_W-1:0] emit_q, emit_d;       // index of record being emitted
	logic [IDX_W-1:0] last_idx;

	// RAM ports
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	rbs_pkg::rec_t    ram_wdata;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	rbs_pkg::rec_t    rd_rec;

	// output register
	logic                      out_valid_q;
	logic [rbs_pkg::KEY_W-1:0] out_key_q;
	logic [rbs_pkg::PAY_W-1:0] out_payload_q;
	logic                      out_last_q;
	logic                      overflow_q;
	logic                      out_free;
	logic                      out_load;

	rbs_ram #(
		.WIDTH (rbs_pkg::REC_W),
		.DEPTH (MAX_RECORDS),
		.ADDR_W(IDX_W)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rd_rec)
	);

	// count is at least one whenever this is used
	assign last_idx = IDX_W'(count_q - CNT_W'(1));
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rbs_pkg::S_LOAD;
			count_q   <= '0;
			dropped_q <= 1'b0;
			swapped_q <= 1'b0;
			pos_q     <= '0;
			emit_q    <= '0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			dropped_q <= dropped_d;
			swapped_q <= swapped_d;
			pos_q     <= pos_d;
			emit_q    <= emit_d;
		end
	end

	always_ff @(posedge clk) begin
		hold_q <= hold_d;
	end

	// Sequencer: load, bubble passes with a held record, emit.
	// A pass reads entry 0 into hold, then for each next entry writes the
	// smaller of hold/entry one slot down and keeps the larger in hold.
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		dropped_d = dropped_q;
		swapped_d = swapped_q;
		hold_d    = hold_q;
		pos_d     = pos_q;
		emit_d    = emit_q;
		in_stall  = 1'b1;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = hold_q;
		ram_re    = 1'b0;
		ram_raddr = '0;
		out_load  = 1'b0;

		unique case (state_q)
			rbs_pkg::S_LOAD: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (count_q < CNT_W'(MAX_RECORDS)) begin
						ram_we    = 1'b1;
						ram_waddr = count_q[IDX_W-1:0];
						ram_wdata = {sort_key, payload};
						count_d   = count_q + CNT_W'(1);
					end else begin
						dropped_d = 1'b1;
					end
					if (last_item) begin
						emit_d = '0;
						if (count_d >= CNT_W'(2)) begin
							state_d = rbs_pkg::S_SORT_START;
						end else begin
							state_d = rbs_pkg::S_EMIT_RD;
						end
					end
				end
			end
			rbs_pkg::S_SORT_START: begin
				ram_re    = 1'b1;
				ram_raddr = '0;
				swapped_d = 1'b0;
				state_d   = rbs_pkg::S_SORT_FIRST;
			end
			rbs_pkg::S_SORT_FIRST: begin
				hold_d    = rd_rec;
				ram_re    = 1'b1;
				ram_raddr = IDX_W'(1);
				pos_d     = IDX_W'(1);
				state_d   = rbs_pkg::S_SORT_STEP;
			end
			rbs_pkg::S_SORT_STEP: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q - IDX_W'(1);
				if (hold_q.key > rd_rec.key) begin
					// strict compare keeps equal keys in order
					ram_wdata = rd_rec;
					swapped_d = 1'b1;
				end else begin
					ram_wdata = hold_q;
					hold_d    = rd_rec;
				end
				if (pos_q == last_idx) begin
					state_d = rbs_pkg::S_SORT_TAIL;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = pos_q + IDX_W'(1);
					pos_d     = pos_q + IDX_W'(1);
				end
			end
			rbs_pkg::S_SORT_TAIL: begin
				ram_we    = 1'b1;
				ram_waddr = last_idx;
				ram_wdata = hold_q;
				if (swapped_q) begin
					state_d = rbs_pkg::S_SORT_START;
				end else begin
					state_d = rbs_pkg::S_EMIT_RD;
				end
			end
			rbs_pkg::S_EMIT_RD: begin
				ram_re    = 1'b1;
				ram_raddr = emit_q;
				state_d   = rbs_pkg::S_EMIT_LD;
			end
			rbs_pkg::S_EMIT_LD: begin
				// read data holds entry emit_q until the output register frees
				if (out_free) begin
					out_load = 1'b1;
					if (emit_q == last_idx) begin
						count_d   = '0;
						dropped_d = 1'b0;
						state_d   = rbs_pkg::S_LOAD;
					end else begin
						emit_d    = emit_q + IDX_W'(1);
						ram_re    = 1'b1;
						ram_raddr = emit_q + IDX_W'(1);
					end
				end
			end
			default: begin
				state_d = rbs_pkg::S_LOAD;
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_key_q     <= rd_rec.key;
			out_payload_q <= rd_rec.payload;
			out_last_q    <= (emit_q == last_idx);
			overflow_q    <= dropped_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_key     = out_key_q;
	assign out_payload = out_payload_q;
	assign out_last    = out_last_q;
	assign overflow    = overflow_q;

endmodule

// ----- hw/rtl/rbs_checker.sv -----
// ----------------------------------------------------------------------------
// rbs_checker
// Port-level checks for the record bubble-sort core, bound to the top level.
// ----------------------------------------------------------------------------
module rbs_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      last_item,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [rbs_pkg::KEY_W-1:0] out_key,
	input logic [rbs_pkg::PAY_W-1:0] out_payload,
	input logic                      out_last
);

	// closing word starts sort/emit, input is held off
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && last_item) |=> in_stall)
		else $error("input not stalled after closing word");

	// a word that does not close the set keeps the core loading
	a_load_open: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !last_item) |=> !in_stall)
		else $error("input stalled in the middle of a set");

	// while a run is still being emitted, no new word is taken
	a_emit_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_last) |-> in_stall)
		else $error("input open while sorted run incomplete");

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_key) &&
		$stable(out_payload) && $stable(out_last)))
		else $error("stalled output word changed");

endmodule

bind record_bubble_sort_core rbs_checker u_rbs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.last_item  (last_item),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.out_key    (out_key),
	.out_payload(out_payload),
	.out_last   (out_last)
);
